// File: hdl/rcpnt_pkg.sv
// Shared types, codes and constants of the RC pulse nibble serial transmitter.
package rcpnt_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_CHECKSUM = 2'd1,
    OP_TICK     = 2'd2,
    OP_FLUSH    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  symbol;
    logic [10:0] width_us;
    logic        tx_idle;
  } result_t;

  localparam logic [0:0] REG_REPEAT_COUNT = 1'b0;
  localparam logic [0:0] REG_SWEEP_ENABLE = 1'b1;

  localparam logic [4:0]  SYM_REPEAT    = 5'd16;
  localparam logic [4:0]  SYM_IDLE      = 5'd17;
  localparam logic [4:0]  SYM_MAX       = 5'd17;
  localparam logic [10:0] PULSE_BASE_US = 11'd1024;
  localparam logic [10:0] PULSE_STEP_US = 11'd56;
  localparam logic [7:0]  CHECK_MASK    = 8'h55;

endpackage

// File: hdl/rcpnt_front.sv
// Input stage: accepts items, decodes their kind and queues them for execution.
module rcpnt_front
  import rcpnt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic [1:0] s_axis_tuser,   // kind
  output item_t      q_item,
  output logic       q_valid,
  input  logic       q_pop
);

  item_t      slot [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] count;
  logic       push;

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign q_item        = slot[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (q_pop) begin
        rd_sel <= ~rd_sel;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= '{op: op_t'(s_axis_tuser), data: s_axis_tdata};
    end
  end

endmodule

// File: hdl/rcpnt_back.sv
// Execution stage: byte store, symbol selection, hold timing and the output register.
module rcpnt_back
  import rcpnt_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  item_t       q_item,
  input  logic        q_valid,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [7:0]       store [FIFO_DEPTH];
  logic [7:0]       rd_q;

  logic [7:0]       repeat_count;
  logic             sweep_enable;

  logic [PTR_W-1:0] rp, rp_next, wp, wp_next, rp_inc, wp_inc, rd_addr;
  logic [7:0]       running_xor, running_xor_next;
  logic             empty, empty_next;
  logic             half, half_next;
  logic [7:0]       held, held_next;
  logic [4:0]       cur, cur_next;
  logic [4:0]       prev, prev_next;
  logic             busy, busy_next;
  logic [7:0]       hold, hold_next;
  logic             desc, desc_next;
  logic             sweep_desc_hit;

  logic             fire;
  logic             mem_we;
  logic [7:0]       wbyte;
  logic [4:0]       s;
  result_t          res, res_q;

  assign fire   = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign q_pop  = fire;
  assign wp_inc = (wp == PTR_LAST) ? '0 : wp + 1'b1;
  assign rp_inc = (rp == PTR_LAST) ? '0 : rp + 1'b1;
  assign wbyte  = (q_item.op == OP_WRITE) ? q_item.data : (running_xor ^ CHECK_MASK);
  assign sweep_desc_hit = (cur == 5'd0);

  always_comb begin
    rp_next          = rp;
    wp_next          = wp;
    running_xor_next = running_xor;
    empty_next       = empty;
    half_next        = half;
    held_next        = held;
    cur_next         = cur;
    prev_next        = prev;
    busy_next        = busy;
    hold_next        = hold;
    desc_next        = desc;
    mem_we           = 1'b0;
    s                = SYM_IDLE;
    res              = '0;
    unique case (q_item.op) inside
      OP_WRITE, OP_CHECKSUM: begin
        if (wp_inc != rp) begin
          mem_we           = 1'b1;
          wp_next          = wp_inc;
          running_xor_next = running_xor ^ wbyte;
          empty_next       = 1'b0;
          res.accepted     = 1'b1;
        end
      end
      OP_TICK: begin
        if (!busy) begin
          if (sweep_enable) begin
            if (desc) begin
              if (sweep_desc_hit) begin
                desc_next = 1'b0;
                cur_next  = 5'd1;
              end else begin
                cur_next = cur - 5'd1;
              end
            end else if (cur >= SYM_MAX) begin
              desc_next = 1'b1;
              cur_next  = SYM_MAX - 5'd1;
            end else begin
              cur_next = cur + 5'd1;
            end
          end else begin
            if (!half) begin
              if (rp != wp) begin
                held_next = rd_q;
                rp_next   = rp_inc;
                s         = {1'b0, rd_q[7:4]};
                half_next = 1'b1;
              end else begin
                s                = SYM_IDLE;
                empty_next       = 1'b1;
                running_xor_next = 8'd0;
              end
            end else begin
              s         = {1'b0, held[3:0]};
              half_next = 1'b0;
            end
            if (s == prev) begin
              s = SYM_REPEAT;
            end
            prev_next = s;
            cur_next  = s;
          end
        end
        res.symbol   = cur_next;
        res.width_us = PULSE_BASE_US + PULSE_STEP_US * {6'd0, cur_next};
        if (hold >= repeat_count) begin
          hold_next = 8'd0;
          busy_next = 1'b0;
        end else begin
          hold_next = hold + 8'd1;
          busy_next = 1'b1;
        end
      end
      OP_FLUSH: begin
        rp_next = '0;
        wp_next = '0;
      end
      default: begin
      end
    endcase
    res.tx_idle = empty_next;
  end

  assign rd_addr = fire ? rp_next : rp;

  always_ff @(posedge clk) begin
    if (fire && mem_we) begin
      store[wp] <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && mem_we && (wp == rd_addr)) begin
      rd_q <= wbyte;
    end else begin
      rd_q <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count <= 8'd0;
      sweep_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPEAT_COUNT: repeat_count <= cfg_data;
        REG_SWEEP_ENABLE: sweep_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp            <= '0;
      wp            <= '0;
      running_xor   <= 8'd0;
      empty         <= 1'b1;
      half          <= 1'b0;
      held          <= 8'd0;
      cur           <= 5'd0;
      prev          <= 5'd0;
      busy          <= 1'b0;
      hold          <= 8'd0;
      desc          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        rp            <= rp_next;
        wp            <= wp_next;
        running_xor   <= running_xor_next;
        empty         <= empty_next;
        half          <= half_next;
        held          <= held_next;
        cur           <= cur_next;
        prev          <= prev_next;
        busy          <= busy_next;
        hold          <= hold_next;
        desc          <= desc_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {6'd0, res_q.tx_idle, res_q.width_us, res_q.symbol,
                         res_q.accepted};

endmodule

// File: hdl/rc_pulse_nibble_serial_tx.sv
// Sends queued bytes as RC servo pulse-width symbols, one result per item.
// Each item produces exactly one result, and the block takes one item per
// clock while the output is not stalled: an item waits in a two-entry input
// queue, is executed as it leaves the queue and its result appears on the
// master side in the next cycle. The execution stage sets the rate; its byte
// store is a memory with one write and one registered read port and holds
// FIFO_DEPTH-1 bytes. With sweep off, a sync tick sends the high nibble and
// then the low nibble of the oldest byte, idle (17) when the store is empty
// and repeat (16) for a symbol equal to the previous one; each symbol lasts
// repeat_count+1 ticks, and the reported width is 1024 + 56 * symbol us. The
// user must ensure configuration is written only while idle; not enforced.
module rc_pulse_nibble_serial_tx
  import rcpnt_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // accepted, symbol, width in us, tx_idle, zero fill
);

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  rcpnt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  rcpnt_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: hdl/rcpnt_checker.sv
// Port-level checks of the transmitter and their binding to the top level.
module rcpnt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_width_matches_symbol: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5:1] <= 5'd17) &&
      ((m_axis_tdata[16:6] == 11'd0 && m_axis_tdata[5:1] == 5'd0) ||
       (m_axis_tdata[16:6] == 11'd1024 + 11'd56 * {6'd0, m_axis_tdata[5:1]})))
    else $error("pulse width does not match symbol");

  a_accept_not_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tdata[16:6] == 11'd0 && !m_axis_tdata[17])
    else $error("accepted byte with tick or idle status");

endmodule

bind rc_pulse_nibble_serial_tx rcpnt_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
